[rtl/core/cds_pkg.sv]
`timescale 1ns / 1ps

package cds_pkg;

  // Widths of the request and result fields.
  localparam int PERIOD_W   = 31;
  localparam int CLOCK_W    = 16;
  localparam int DIVISOR_W  = 16;
  localparam int ACHIEVED_W = 32;

  // Default upper bound for either divisor.
  localparam int DIVISOR_MAX_DEF = 65535;

  // Configuration register map.
  localparam int                  PADDR_W         = 2;
  localparam logic [PADDR_W-1:0]  ADDR_BASE_CLOCK = 2'd0;
  localparam logic [CLOCK_W-1:0]  BASE_CLOCK_RST  = 16'd1000;

  // The quotient of the period by the trial step has one bit per period bit.
  localparam int DIV_STEPS = PERIOD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the request and reset the search
    logic div_start;  // divide the period by the current step
    logic eval_lo;    // score the pair (a, q)
    logic eval_hi;    // score the pair (a, q+1) and advance a
    logic finish;     // latch the result registers
  } cds_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clk_zero;   // counter clock period is zero
    logic loop_ok;    // current a is still inside the search range
    logic div_done;   // quotient and remainder are ready
  } cds_sts_t;

endpackage

[rtl/core/cascaded_divisor_search_unit.sv]
`timescale 1ns / 1ps

// Channel    | Handshake                 | Payload
// -----------+---------------------------+------------------------------------------
// request    | start, busy               | in_target_period
// result     | out_valid (one cycle)     | out_divisor_first, out_divisor_second,
//            |                           | out_achieved_period, out_fail_flag
// config     | psel, penable, pwrite,    | paddr, pwdata, prdata
//            | pready                    |
//
// A request is taken when start is high and busy is low. The search tries
// first divisors a = 1, 2, ... for as long as a*a*clock < 2*period and
// a <= period/(2*clock)+1. Each trial makes one pass of the shared bit-serial
// divider plus the control and scoring steps; a request makes N trials, and
// N reaches 65535 at most. Reset is synchronous and active low; it returns
// the controller to idle and the counter clock register to 1000 ns. The
// result is shown for exactly one cycle on out_valid and is never held off;
// busy falls in that same cycle.

module cascaded_divisor_search_unit import cds_pkg::*; #(
  parameter int DIVISOR_MAX = DIVISOR_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  start,
  output logic                  busy,
  input  logic [PERIOD_W-1:0]   in_target_period,
  // result channel
  output logic                  out_valid,
  output logic [DIVISOR_W-1:0]  out_divisor_first,
  output logic [DIVISOR_W-1:0]  out_divisor_second,
  output logic [ACHIEVED_W-1:0] out_achieved_period,
  output logic                  out_fail_flag,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cds_cmd_t           cmd;
  cds_sts_t           sts;
  logic [CLOCK_W-1:0] base_clock_r;
  logic               cfg_write;

  // The bus never waits; a write lands at the end of its access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_clock_r <= BASE_CLOCK_RST;
    end else if (cfg_write && (paddr == ADDR_BASE_CLOCK)) begin
      base_clock_r <= pwdata[CLOCK_W-1:0];
    end
  end

  // Unmapped addresses read as zero.
  assign prdata = (paddr == ADDR_BASE_CLOCK) ? {16'b0, base_clock_r} : 32'b0;

  // The controller sequences the search; the datapath keeps the running
  // best pair and owns the divider.
  cds_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done_strobe (out_valid),
    .cmd         (cmd),
    .sts         (sts)
  );

  cds_dp #(
    .DIVISOR_MAX (DIVISOR_MAX)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .base_clock      (base_clock_r),
    .target_period   (in_target_period),
    .divisor_first   (out_divisor_first),
    .divisor_second  (out_divisor_second),
    .achieved_period (out_achieved_period),
    .fail_flag       (out_fail_flag)
  );

endmodule

[rtl/core/cds_div.sv]
`timescale 1ns / 1ps

module cds_div import cds_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [PERIOD_W-1:0] dividend,
  input  logic [31:0]         divisor,
  output logic                done,
  output logic [PERIOD_W-1:0] quotient,
  output logic [31:0]         remainder
);

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [PERIOD_W-1:0]  quo_r;
  logic [31:0]          rem_r;
  logic [31:0]          dsr_r;
  logic [32:0]          trial;
  logic [32:0]          diff;
  logic                 fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_r, quo_r[PERIOD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[PERIOD_W-2:0], fits};
      rem_r <= fits ? diff[31:0] : trial[31:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/core/cds_dp.sv]
`timescale 1ns / 1ps

module cds_dp import cds_pkg::*; #(
  parameter int DIVISOR_MAX = DIVISOR_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cds_cmd_t              cmd,
  output cds_sts_t              sts,
  input  logic [CLOCK_W-1:0]    base_clock,
  input  logic [PERIOD_W-1:0]   target_period,
  output logic [DIVISOR_W-1:0]  divisor_first,
  output logic [DIVISOR_W-1:0]  divisor_second,
  output logic [ACHIEVED_W-1:0] achieved_period,
  output logic                  fail_flag
);

  localparam logic [31:0] DMAX = 32'(DIVISOR_MAX);

  logic [PERIOD_W-1:0]   p_r;
  logic [16:0]           a_r;       // trial first divisor
  logic [32:0]           step_r;    // a * clock
  logic [34:0]           sq_r;      // a * a * clock
  logic [31:0]           best_r;    // smallest error so far
  logic [DIVISOR_W-1:0]  best_a_r;
  logic [31:0]           best_b_r;
  logic [31:0]           best_prod_r;
  logic [DIVISOR_W-1:0]  out_a_r;
  logic [DIVISOR_W-1:0]  out_b_r;
  logic [ACHIEVED_W-1:0] out_prod_r;
  logic                  out_fail_r;

  logic                  div_done;
  logic [PERIOD_W-1:0]   div_quo;
  logic [31:0]           div_rem;
  logic [32:0]           step_less;
  logic [31:0]           err_hi;
  logic [31:0]           prod_lo;
  logic [31:0]           prod_hi;
  logic [31:0]           b_hi;
  logic                  fail;

  cds_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (p_r),
    .divisor   (step_r[31:0]),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Range test: a <= p/(2c)+1 is the same as 2*(a-1)*c <= p, and the
  // search goes on only while a*a*c < 2p.
  assign step_less    = step_r - {17'b0, base_clock};
  assign sts.loop_ok  = (sq_r < {3'b0, p_r, 1'b0}) &&
                        ({step_less, 1'b0} <= {3'b0, p_r});
  assign sts.clk_zero = (base_clock == '0);
  assign sts.div_done = div_done;

  // With r = p - q*step, the pair (a, q) misses by r from below and the
  // pair (a, q+1) misses by step - r from above.
  assign prod_lo = {1'b0, p_r} - div_rem;
  assign prod_hi = prod_lo + step_r[31:0];
  assign err_hi  = step_r[31:0] - div_rem;
  assign b_hi    = {1'b0, div_quo} + 32'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r      <= target_period;
      a_r      <= 17'd1;
      step_r   <= {17'b0, base_clock};
      sq_r     <= {19'b0, base_clock};
      best_r   <= {1'b0, target_period};
      best_a_r <= '0;
      best_b_r <= '0;
    end else if (cmd.eval_lo) begin
      if (div_rem < best_r) begin
        best_r      <= div_rem;
        best_a_r    <= a_r[DIVISOR_W-1:0];
        best_b_r    <= {1'b0, div_quo};
        best_prod_r <= prod_lo;
      end
    end else if (cmd.eval_hi) begin
      if (err_hi < best_r) begin
        best_r      <= err_hi;
        best_a_r    <= a_r[DIVISOR_W-1:0];
        best_b_r    <= b_hi;
        best_prod_r <= prod_hi;
      end
      a_r    <= a_r + 17'd1;
      step_r <= step_r + {17'b0, base_clock};
      sq_r   <= sq_r + {1'b0, step_r, 1'b0} + {19'b0, base_clock};
    end
  end

  // A search that never improved leaves the first divisor at zero.
  assign fail = (best_a_r == '0) || ({16'b0, best_a_r} > DMAX) ||
                (best_b_r == '0) || (best_b_r > DMAX);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_a_r    <= fail ? '0 : best_a_r;
      out_b_r    <= fail ? '0 : best_b_r[DIVISOR_W-1:0];
      out_prod_r <= fail ? '0 : best_prod_r;
      out_fail_r <= fail;
    end
  end

  assign divisor_first   = out_a_r;
  assign divisor_second  = out_b_r;
  assign achieved_period = out_prod_r;
  assign fail_flag       = out_fail_r;

endmodule

[rtl/core/cds_ctrl.sv]
`timescale 1ns / 1ps

module cds_ctrl import cds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     done_strobe,
  output cds_cmd_t cmd,
  input  cds_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EVAL_LO,
    ST_EVAL_HI
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;
  logic   stop;

  assign stop = sts.clk_zero || !sts.loop_ok;

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stop) begin
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_EVAL_LO;
        end
      end
      ST_EVAL_LO: begin
        state_nxt = ST_EVAL_HI;
      end
      ST_EVAL_HI: begin
        state_nxt = ST_CHECK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == ST_IDLE) && start;
    cmd.div_start = (state_r == ST_CHECK) && !stop;
    cmd.finish    = (state_r == ST_CHECK) && stop;
    cmd.eval_lo   = (state_r == ST_EVAL_LO);
    cmd.eval_hi   = (state_r == ST_EVAL_HI);
  end

  assign busy        = (state_r != ST_IDLE);
  assign done_strobe = strobe_r;

endmodule

[rtl/core/cds_chk.sv]
`timescale 1ns / 1ps

module cds_chk import cds_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [DIVISOR_W-1:0]  out_divisor_first,
  input logic [DIVISOR_W-1:0]  out_divisor_second,
  input logic [ACHIEVED_W-1:0] out_achieved_period,
  input logic                  out_fail_flag
);

  // A failed search reports all value fields as zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fail_flag |->
      (out_divisor_first == '0) && (out_divisor_second == '0) &&
      (out_achieved_period == '0))
    else $error("failed result carries nonzero fields");

  // A good result has two real divisors and a nonzero period.
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fail_flag |->
      (out_divisor_first != '0) && (out_divisor_second != '0) &&
      (out_achieved_period != '0))
    else $error("good result with a zero field");

  // A result only appears as the search ends, and the unit is then free.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result strobe outside the end of a search");

  // Every finished search delivers a result.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid)
    else $error("search ended without a result");

  // An accepted request occupies the unit on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("request accepted but unit not busy");

endmodule

bind cascaded_divisor_search_unit cds_chk u_cds_chk (.*);

[tb/tb.sv]
`timescale 1ns / 1ps

// Testbench for the cascaded divisor search unit.
//
// Requests carry a target period in ns. For each request the unit searches
// for two cascaded counter divisors whose product, times the counter clock
// period held in the base_clock_ns register, comes closest to the target.
// A request-queue driver feeds the request channel and a monitor checks every
// one-cycle result strobe against a predictor of the search.
module tb;
  import cds_pkg::*;

  // The slowest request issued here is the full-scale period at a 1000 ns
  // clock, with about 2072 trials. The watchdog allows several times the
  // length of that search without any handshake.
  localparam int WATCHDOG_LIMIT = 300000;
  // Quiet cycles after the last result, to catch a stray strobe.
  localparam int DRAIN_CYCLES   = 60;
  // Upper bound of period/clock for the wide random class, which keeps these
  // requests to about 200 trials.
  localparam int RATIO_CAP      = 20000;
  localparam int RANDOM_PHASES  = 10;

  // One search answer, as the result ports present it.
  typedef struct {
    logic [DIVISOR_W-1:0]  div_first;
    logic [DIVISOR_W-1:0]  div_second;
    logic [ACHIEVED_W-1:0] achieved;
    logic                  fail;
  } divisor_pair_t;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  start            = 1'b0;
  logic [PERIOD_W-1:0]   in_target_period = '0;
  logic                  psel             = 1'b0;
  logic                  penable          = 1'b0;
  logic                  pwrite           = 1'b0;
  logic [PADDR_W-1:0]    paddr            = '0;
  logic [31:0]           pwdata           = '0;

  logic                  busy;
  logic                  out_valid;
  logic [DIVISOR_W-1:0]  out_divisor_first;
  logic [DIVISOR_W-1:0]  out_divisor_second;
  logic [ACHIEVED_W-1:0] out_achieved_period;
  logic                  out_fail_flag;
  logic [31:0]           prdata;
  logic                  pready;

  // Periods waiting to be issued, and the answers of accepted requests that
  // have not come back yet, oldest first.
  logic [PERIOD_W-1:0]   pending_periods[$];
  divisor_pair_t         expected_results[$];

  // Our own copy of the counter clock register.
  logic [CLOCK_W-1:0]    clock_ns_model = BASE_CLOCK_RST;

  // Chance, in percent, that the driver leaves a cycle without a request.
  int unsigned           sender_gap_pct = 10;
  int unsigned           mismatches     = 0;
  int unsigned           quiet_cycles   = 0;
  // Set by the monitor at the edge where a request was taken.
  bit                    request_taken  = 1'b0;

  cascaded_divisor_search_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_target_period    (in_target_period),
    .out_valid           (out_valid),
    .out_divisor_first   (out_divisor_first),
    .out_divisor_second  (out_divisor_second),
    .out_achieved_period (out_achieved_period),
    .out_fail_flag       (out_fail_flag),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #10 clk = ~clk;

  // Predictor. Walks the first divisor upward and scores the two second
  // divisors that bracket the target; only a strictly smaller error wins, so
  // on a tie the earlier pair stays. The search stops once a*a*clock reaches
  // twice the period, because no larger first divisor can win after that.
  function automatic divisor_pair_t search_divisors(logic [PERIOD_W-1:0] period,
                                                    logic [CLOCK_W-1:0] clock_ns);
    longint unsigned p, c, best_err, last_a, a, b, q, step, prod, err;
    longint unsigned best_a, best_b;
    bit              found;
    divisor_pair_t   res;
    p        = period;
    c        = clock_ns;
    best_err = p;
    best_a   = 0;
    best_b   = 0;
    found    = 1'b0;
    res.div_first  = '0;
    res.div_second = '0;
    res.achieved   = '0;
    res.fail       = 1'b1;
    // A zero clock period can never be searched and always fails.
    if (c != 0) begin
      last_a = p / (2 * c) + 1;
      for (a = 1; a <= last_a && a * a * c < 2 * p; a++) begin
        step = a * c;
        q    = p / step;
        for (b = q; b <= q + 1; b++) begin
          prod = step * b;
          err  = (prod > p) ? prod - p : p - prod;
          if (err < best_err) begin
            best_err = err;
            best_a   = a;
            best_b   = b;
            found    = 1'b1;
          end
        end
      end
    end
    // A zero period leaves nothing to improve on. A winner whose divisor
    // does not fit a counter also reports a failure with zero fields.
    if (found && best_a >= 1 && best_a <= DIVISOR_MAX_DEF &&
        best_b >= 1 && best_b <= DIVISOR_MAX_DEF) begin
      res.div_first  = DIVISOR_W'(best_a);
      res.div_second = DIVISOR_W'(best_b);
      res.achieved   = ACHIEVED_W'(c * best_a * best_b);
      res.fail       = 1'b0;
    end
    return res;
  endfunction

  // Random target period for the current clock. Most periods are up to 600
  // times the clock period, often an exact multiple or just below the next,
  // so that the search finishes quickly; some are at most twice the clock
  // period, where the search fails or barely starts; a few span a wide range.
  // With a zero clock any period is a failure and costs nothing, so all 31
  // bits are drawn freely there.
  function automatic logic [PERIOD_W-1:0] pick_period(logic [CLOCK_W-1:0] clock_ns);
    longint unsigned c, ratio, offset, ceiling;
    int unsigned     roll;
    c    = clock_ns;
    roll = $urandom_range(0, 99);
    if (c == 0) begin
      return PERIOD_W'($urandom);
    end
    if (roll < 70) begin
      ratio = $urandom_range(0, 600);
      case ($urandom_range(0, 3))
        0: begin
          offset = 0;
        end
        1: begin
          offset = c - 1;
        end
        default: begin
          offset = $urandom_range(0, 32'(c - 1));
        end
      endcase
      return PERIOD_W'(ratio * c + offset);
    end
    if (roll < 90) begin
      return PERIOD_W'($urandom_range(0, 32'(2 * c)));
    end
    ceiling = c * RATIO_CAP;
    if (ceiling > 64'h7fff_ffff) begin
      ceiling = 64'h7fff_ffff;
    end
    return PERIOD_W'($urandom_range(0, 32'(ceiling)));
  endfunction

  // Reports a field that differs from its expected value.
  task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Waits until every queued request has been issued and answered. The test
  // is made a moment after the falling edge, once the driver's update of
  // start has settled, so a request popped at that edge is never missed.
  task automatic wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (pending_periods.size() != 0 || expected_results.size() != 0 || start || busy);
  endtask

  // Writes the clock register once the unit is idle, then reads it back.
  // Only the low 16 bits of the write data are kept, so a value with junk in
  // the upper half also checks that they are dropped.
  task automatic write_clock(logic [31:0] value);
    wait_idle();
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BASE_CLOCK;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    clock_ns_model = value[CLOCK_W-1:0];
    // Read-back transfer follows directly with a new setup cycle.
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("base_clock_ns read-back", clock_ns_model, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Request driver. A new request is considered once the previous one was
  // taken or none is up; start stays high across back-to-back requests, so
  // it is never lowered and raised in the same step.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || request_taken) begin
      if (pending_periods.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct) begin
        start            <= 1'b1;
        in_target_period <= pending_periods.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. A taken request gets its answer predicted right away with the
  // clock value in force; the register only changes while the unit is idle.
  // Each result strobe is compared with the oldest answer still waiting.
  always @(posedge clk) begin : result_monitor
    divisor_pair_t want;
    request_taken = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        request_taken = 1'b1;
        expected_results.push_back(search_divisors(in_target_period, clock_ns_model));
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding: expected none, actual %0d %0d %0d %0d",
                   $time, out_divisor_first, out_divisor_second, out_achieved_period,
                   out_fail_flag);
        end else begin
          want = expected_results.pop_front();
          check_field("divisor_first", want.div_first, out_divisor_first);
          check_field("divisor_second", want.div_second, out_divisor_second);
          check_field("achieved_period", want.achieved, out_achieved_period);
          check_field("fail_flag", want.fail, out_fail_flag);
        end
      end
    end
  end

  // Watchdog: any request, result or register transfer counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired after %0d cycles without progress", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset clock of 1000 ns: zero period, periods
    // below one clock, an exact single clock, ties between both bracketing
    // pairs (1500 and 2500), values just around twice the clock, and full scale.
    pending_periods = {31'd0, 31'd1, 31'd999, 31'd1000, 31'd1500, 31'd1999,
                       31'd2000, 31'd2500, 31'h7fff_ffff};

    // Fastest clock of 1 ns: tiny periods, the largest period that still
    // fits one counter, and exact fits whose second divisor overflows.
    write_clock(32'd1);
    pending_periods = {31'd1, 31'd2, 31'd3, 31'd65535, 31'd70000, 31'd131072};

    // Slowest clock: full scale and periods around the clock period and twice it.
    write_clock(32'd65535);
    pending_periods = {31'h7fff_ffff, 31'd65534, 31'd65535, 31'd131070};

    // Zero clock period always fails, whatever the request.
    write_clock(32'd0);
    pending_periods = {31'h7fff_ffff, 31'd12345};

    // Random phases over a spread of clock settings. The 1000 ns phase runs
    // without any gaps between requests.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      logic [31:0] clock_value;
      int unsigned n_requests;
      n_requests     = 32;
      sender_gap_pct = 10;
      case (phase)
        0: clock_value = 32'hffff_0001;
        1: clock_value = 32'h0000_ffff;
        2: clock_value = 32'ha5a5_0000 | $urandom_range(2, 20);
        3: begin
          clock_value    = 32'd1000;
          sender_gap_pct = 0;
        end
        4: begin
          clock_value = 32'd0;
          n_requests  = 10;
        end
        5: clock_value = $urandom_range(1, 65535);
        6: clock_value = ($urandom & 32'hffff_0000) | $urandom_range(1, 65535);
        7: clock_value = $urandom_range(100, 5000);
        8: clock_value = $urandom_range(20000, 65535);
        default: clock_value = $urandom_range(1, 3);
      endcase
      write_clock(clock_value);
      repeat (n_requests) pending_periods.push_back(pick_period(clock_ns_model));
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
